@@ design/wtsp_pkg.sv @@
`timescale 1ns / 1ps

package wtsp_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 32;
  localparam int CFG_W     = 64;
  localparam int SCR_W     = 15;
  localparam int MTX_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int ROWS      = 3;
  localparam int AXES      = 3;

  localparam int PROD_W   = COORD_W + COEF_W;
  localparam int SC_W     = COORD_W + COEF_W - FRAC_BITS;
  localparam int SUM_W    = SC_W + 2;
  localparam int W_W      = SUM_W - 2;
  localparam int CLIP_EXP = 62 - FRAC_BITS;
  localparam int MAG_W    = CLIP_EXP + 1;
  localparam int DVD_W    = MAG_W + FRAC_BITS;
  localparam int W_MIN    = (2 ** FRAC_BITS) / 100;
  localparam int Q_W      = DVD_W - ($clog2(W_MIN + 1) - 1);
  localparam int NDC_EXP  = 47;
  localparam int QS_W     = NDC_EXP + 1;
  localparam int NDC_W    = NDC_EXP + 2;
  localparam int VP_W     = NDC_W + SCR_W + 1;
  localparam int FIN_W    = VP_W + 1;

  localparam logic [SCR_W-1:0] WIDTH_RST  = SCR_W'(1920);
  localparam logic [SCR_W-1:0] HEIGHT_RST = SCR_W'(1080);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_01,
    REG_ROW0_23,
    REG_ROW1_01,
    REG_ROW1_23,
    REG_ROW3_01,
    REG_ROW3_23,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_t;

  typedef logic [MTX_REGS-1:0][CFG_W-1:0] mtx_t;

  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] cx;
    logic signed [SUM_W-1:0] cy;
    logic signed [SUM_W-1:0] w;
  } dot_out_t;

  typedef struct packed {
    logic                    valid;
    logic                    vis;
    logic signed [NDC_W-1:0] nx;
    logic signed [NDC_W-1:0] ny;
  } div_out_t;

  typedef struct packed {
    logic               valid;
    logic               vis;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
  } view_out_t;

  // row 0, 1, 2 here map to matrix rows 0, 1, 3
  function automatic logic signed [COEF_W-1:0] coef(input mtx_t m, input int row,
                                                    input int col);
    logic [CFG_W-1:0] word;
    word = m[row * 2 + (col >> 1)];
    coef = col[0] ? word[CFG_W-1:COEF_W] : word[COEF_W-1:0];
  endfunction

endpackage

@@ design/wtsp_dot.sv @@
`timescale 1ns / 1ps

module wtsp_dot import wtsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic signed [COORD_W-1:0] pz,
  input  mtx_t                      mtx,
  output dot_out_t                  dout
);

  localparam logic signed [PROD_W-1:0] RND = PROD_W'((2 ** FRAC_BITS) - 1);

  logic                      v0_r, v1_r, v2_r;
  logic signed [COORD_W-1:0] pt_r   [AXES];
  logic signed [PROD_W-1:0]  prod_r [ROWS][AXES];
  logic signed [PROD_W-1:0]  prod_nxt [ROWS][AXES];
  logic signed [SC_W-1:0]    sc_r   [ROWS][AXES];
  logic signed [SC_W-1:0]    sc_nxt [ROWS][AXES];
  logic signed [SUM_W-1:0]   sum_nxt [ROWS];
  dot_out_t                  dout_r;

  // coefficient times coordinate, one multiplier per lane
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < AXES; c++) begin
        prod_nxt[r][c] = PROD_W'(coef(mtx, r, c)) * PROD_W'(pt_r[c]);
      end
    end
  end

  // scale back, truncating toward zero
  always_comb begin
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] s;
    t = '0;
    s = '0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < AXES; c++) begin
        t = prod_r[r][c] + (prod_r[r][c][PROD_W-1] ? RND : '0);
        s = t >>> FRAC_BITS;
        sc_nxt[r][c] = s[SC_W-1:0];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      sum_nxt[r] = SUM_W'(sc_r[r][0]) + SUM_W'(sc_r[r][1]) + SUM_W'(sc_r[r][2])
                 + SUM_W'(coef(mtx, r, 3));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      dout_r.valid <= 1'b0;
    end else if (en) begin
      v0_r         <= in_valid;
      v1_r         <= v0_r;
      v2_r         <= v1_r;
      dout_r.valid <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r[0]   <= px;
      pt_r[1]   <= py;
      pt_r[2]   <= pz;
      prod_r    <= prod_nxt;
      sc_r      <= sc_nxt;
      dout_r.cx <= sum_nxt[0];
      dout_r.cy <= sum_nxt[1];
      dout_r.w  <= sum_nxt[2];
    end
  end

  assign dout = dout_r;

endmodule

@@ design/wtsp_div.sv @@
`timescale 1ns / 1ps

module wtsp_div import wtsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  dot_out_t din,
  output div_out_t dout
);

  localparam logic signed [SUM_W-1:0] CLIP_P  = SUM_W'(1) <<< CLIP_EXP;
  localparam logic signed [SUM_W-1:0] CLIP_N  = -CLIP_P;
  localparam logic signed [SUM_W-1:0] W_MIN_S = SUM_W'(W_MIN);
  localparam logic [Q_W-1:0]          Q_LIM   = Q_W'(1) << NDC_EXP;

  logic             v_r    [Q_W+1];
  logic             vis_r  [Q_W+1];
  logic             sgx_r  [Q_W+1];
  logic             sgy_r  [Q_W+1];
  logic [W_W-1:0]   w_r    [Q_W+1];
  logic [W_W-1:0]   remx_r [Q_W+1];
  logic [W_W-1:0]   remy_r [Q_W+1];
  logic [Q_W-1:0]   lowx_r [Q_W+1];
  logic [Q_W-1:0]   lowy_r [Q_W+1];
  logic [Q_W-1:0]   qx_r   [Q_W+1];
  logic [Q_W-1:0]   qy_r   [Q_W+1];

  logic signed [SUM_W-1:0] clx, cly;
  logic [MAG_W-1:0]        magx, magy;
  logic [DVD_W-1:0]        dvdx, dvdy;
  div_out_t                dout_r;
  div_out_t                dout_nxt;

  // clamp clip values and form the dividend magnitudes
  always_comb begin
    clx  = (din.cx > CLIP_P) ? CLIP_P : ((din.cx < CLIP_N) ? CLIP_N : din.cx);
    cly  = (din.cy > CLIP_P) ? CLIP_P : ((din.cy < CLIP_N) ? CLIP_N : din.cy);
    magx = clx[SUM_W-1] ? MAG_W'(-clx) : MAG_W'(clx);
    magy = cly[SUM_W-1] ? MAG_W'(-cly) : MAG_W'(cly);
    dvdx = {magx, {FRAC_BITS{1'b0}}};
    dvdy = {magy, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r[0]  <= (din.w >= W_MIN_S);
      sgx_r[0]  <= clx[SUM_W-1];
      sgy_r[0]  <= cly[SUM_W-1];
      w_r[0]    <= din.w[W_W-1:0];
      remx_r[0] <= W_W'(dvdx[DVD_W-1:Q_W]);
      remy_r[0] <= W_W'(dvdy[DVD_W-1:Q_W]);
      lowx_r[0] <= dvdx[Q_W-1:0];
      lowy_r[0] <= dvdy[Q_W-1:0];
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
    end
  end

  // one quotient bit per stage, both axes share the divisor
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [W_W:0] rx, ry, dx, dy;
    logic         gex, gey;

    always_comb begin
      rx  = {remx_r[k], lowx_r[k][Q_W-1]};
      ry  = {remy_r[k], lowy_r[k][Q_W-1]};
      gex = (rx >= {1'b0, w_r[k]});
      gey = (ry >= {1'b0, w_r[k]});
      dx  = rx - {1'b0, w_r[k]};
      dy  = ry - {1'b0, w_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vis_r[k+1]  <= vis_r[k];
        sgx_r[k+1]  <= sgx_r[k];
        sgy_r[k+1]  <= sgy_r[k];
        w_r[k+1]    <= w_r[k];
        remx_r[k+1] <= gex ? dx[W_W-1:0] : rx[W_W-1:0];
        remy_r[k+1] <= gey ? dy[W_W-1:0] : ry[W_W-1:0];
        lowx_r[k+1] <= {lowx_r[k][Q_W-2:0], 1'b0};
        lowy_r[k+1] <= {lowy_r[k][Q_W-2:0], 1'b0};
        qx_r[k+1]   <= {qx_r[k][Q_W-2:0], gex};
        qy_r[k+1]   <= {qy_r[k][Q_W-2:0], gey};
      end
    end
  end

  // saturate the quotients and put the signs back
  always_comb begin
    logic [QS_W-1:0] qsx, qsy;
    qsx            = (qx_r[Q_W] > Q_LIM) ? QS_W'(Q_LIM) : qx_r[Q_W][QS_W-1:0];
    qsy            = (qy_r[Q_W] > Q_LIM) ? QS_W'(Q_LIM) : qy_r[Q_W][QS_W-1:0];
    dout_nxt.valid = v_r[Q_W];
    dout_nxt.vis   = vis_r[Q_W];
    dout_nxt.nx    = sgx_r[Q_W] ? -$signed({1'b0, qsx}) : $signed({1'b0, qsx});
    dout_nxt.ny    = sgy_r[Q_W] ? -$signed({1'b0, qsy}) : $signed({1'b0, qsy});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end else if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

@@ design/wtsp_view.sv @@
`timescale 1ns / 1ps

module wtsp_view import wtsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [SCR_W-1:0] scr_w,
  input  logic [SCR_W-1:0] scr_h,
  input  div_out_t         din,
  output view_out_t        dout
);

  localparam logic signed [FIN_W-1:0] HALF_Q = FIN_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [FIN_W-1:0] C_MAX  = (FIN_W'(1) <<< (COORD_W - 1)) - FIN_W'(1);
  localparam logic signed [FIN_W-1:0] C_MIN  = -C_MAX - FIN_W'(1);

  logic                   v1_r, vis1_r;
  logic signed [VP_W-1:0] tx_r, ty_r;
  view_out_t              dout_r;
  view_out_t              dout_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis1_r <= din.vis;
      tx_r   <= VP_W'(din.nx) * VP_W'($signed({1'b0, scr_w}));
      ty_r   <= VP_W'(din.ny) * VP_W'($signed({1'b0, scr_h}));
    end
  end

  always_comb begin
    logic signed [FIN_W-1:0] hw, hh, sx, sy, cx, cy;
    hw = $signed(FIN_W'({scr_w[SCR_W-1:1], {FRAC_BITS{1'b0}}}));
    hh = $signed(FIN_W'({scr_h[SCR_W-1:1], {FRAC_BITS{1'b0}}}));
    sx = hw + FIN_W'(tx_r >>> 1) + HALF_Q;
    sy = hh - (FIN_W'(ty_r >>> 1) + HALF_Q);
    cx = (sx > C_MAX) ? C_MAX : ((sx < C_MIN) ? C_MIN : sx);
    cy = (sy > C_MAX) ? C_MAX : ((sy < C_MIN) ? C_MIN : sy);
    dout_nxt.valid = v1_r;
    dout_nxt.vis   = vis1_r;
    dout_nxt.sx    = vis1_r ? cx[COORD_W-1:0] : '0;
    dout_nxt.sy    = vis1_r ? cy[COORD_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end else if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

@@ design/world_to_screen_projection.sv @@
`timescale 1ns / 1ps
// an accepted word passes the dot, divider and viewport pipelines, then the output register, to out_valid
// throughput: one word per clock while no skid word is held, set by the pipelined divider (one bit a stage)
// a skid register behind the output register keeps in_ready registered
// reset (synchronous, rst_n low) empties the pipeline, zeroes the matrix
// and sets the viewport to 1920 x 1080

module world_to_screen_projection import wtsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_visible,
  output logic signed [COORD_W-1:0] out_screen_x,
  output logic signed [COORD_W-1:0] out_screen_y,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  mtx_t             mtx_r;
  logic [SCR_W-1:0] scr_w_r, scr_h_r;
  logic             en, take;
  dot_out_t         dot_o;
  div_out_t         div_o;
  view_out_t        view_o;
  view_out_t        out_r, skid_r;
  logic             out_v_r, skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtx_r   <= '0;
      scr_w_r <= WIDTH_RST;
      scr_h_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW0_01, REG_ROW0_23, REG_ROW1_01,
        REG_ROW1_23, REG_ROW3_01, REG_ROW3_23: mtx_r[cfg_index] <= cfg_data;
        REG_WIDTH:  scr_w_r <= cfg_data[SCR_W-1:0];
        REG_HEIGHT: scr_h_r <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !skid_v_r;
  assign in_ready = en && rst_n;
  assign take     = en && view_o.valid;

  wtsp_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .px       (in_point_x),
    .py       (in_point_y),
    .pz       (in_point_z),
    .mtx      (mtx_r),
    .dout     (dot_o)
  );

  wtsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .din   (dot_o),
    .dout  (div_o)
  );

  wtsp_view u_view (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .scr_w (scr_w_r),
    .scr_h (scr_h_r),
    .din   (div_o),
    .dout  (view_o)
  );

  // output register with skid word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_r    <= skid_r;
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= take;
        if (take) begin
          out_r <= view_o;
        end
      end
    end else if (take) begin
      skid_r   <= view_o;
      skid_v_r <= 1'b1;
    end
  end

  assign out_valid    = out_v_r;
  assign out_visible  = out_r.vis;
  assign out_screen_x = $signed(out_r.sx);
  assign out_screen_y = $signed(out_r.sy);

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held without an output word");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ready))
    else $error("skid filled while output was free");

  a_invisible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.vis) |-> (out_r.sx == '0 && out_r.sy == '0))
    else $error("invisible point with non-zero coordinates");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import wtsp_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } point_t;

  typedef struct packed {
    logic                      vis;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_visible;
  logic signed [COORD_W-1:0] out_screen_x;
  logic signed [COORD_W-1:0] out_screen_y;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  world_to_screen_projection u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [CFG_W-1:0] view_mtx [MTX_REGS];
  longint unsigned vp_w, vp_h;

  point_t pending_points[$];
  pixel_t expected_pixels[$];
  int n_errors = 0;
  int n_pixels = 0;
  int n_visible = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit hold_off = 1'b0;
  int long_stall = 0;
  int stall_phase = 0;

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint mat_coef(int row, int col);
    logic [CFG_W-1:0] r;
    r = view_mtx[row * 2 + col / 2];
    return (col % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
  endfunction

  function automatic longint scaled_mul(longint c, longint a);
    longint unsigned mc, ma, lo, hi, r;
    bit neg;
    mc = magn(c);
    ma = magn(a);
    lo = (ma & 64'hFFFF_FFFF) * mc;
    hi = (ma >> 32) * mc;
    neg = (c < 0) != (a < 0);
    if (hi >= (64'd1 << (60 - (32 - FRAC_BITS)))) r = 64'd1 << 60;
    else begin
      r = (hi << (32 - FRAC_BITS)) + (lo >> FRAC_BITS);
      if (r > (64'd1 << 60)) r = 64'd1 << 60;
    end
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint row_sum(int row, longint x, longint y, longint z);
    return scaled_mul(mat_coef(row, 0), x) + scaled_mul(mat_coef(row, 1), y)
         + scaled_mul(mat_coef(row, 2), z) + mat_coef(row, 3);
  endfunction

  function automatic longint persp_div(longint c, longint w);
    longint lim;
    longint unsigned q;
    lim = longint'(1) << (62 - FRAC_BITS);
    if (c > lim) c = lim;
    if (c < -lim) c = -lim;
    q = (magn(c) << FRAC_BITS) / longint'(w);
    if (q > (64'd1 << 47)) q = 64'd1 << 47;
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint floor_half(longint t);
    return t >= 0 ? t / 2 : -((-t + 1) / 2);
  endfunction

  function automatic logic [COORD_W-1:0] sat_coord(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[COORD_W-1:0];
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t r;
    longint cx, cy, w, nx, ny, sx, sy;
    cx = row_sum(0, p.px, p.py, p.pz);
    cy = row_sum(1, p.px, p.py, p.pz);
    w = row_sum(2, p.px, p.py, p.pz);
    r = '0;
    if (w < longint'((1 << FRAC_BITS) / 100)) return r;
    nx = persp_div(cx, w);
    ny = persp_div(cy, w);
    sx = (longint'(vp_w >> 1) << FRAC_BITS) + floor_half(nx * longint'(vp_w))
       + (longint'(1) << (FRAC_BITS - 1));
    sy = (longint'(vp_h >> 1) << FRAC_BITS)
       - (floor_half(ny * longint'(vp_h)) + (longint'(1) << (FRAC_BITS - 1)));
    r.vis = 1'b1;
    r.sx = sat_coord(sx);
    r.sy = sat_coord(sy);
    return r;
  endfunction

  // driver: bursts and gaps, prediction at acceptance
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_pixels.push_back(project_point({in_point_x, in_point_y, in_point_z}));
    end
    if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_points.size() > 0 && !hold_off && rst_n) begin
        point_t p;
        p = pending_points.pop_front();
        in_valid <= 1'b1;
        in_point_x <= p.px;
        in_point_y <= p.py;
        in_point_z <= p.pz;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      pixel_t e;
      n_pixels <= n_pixels + 1;
      if (expected_pixels.size() == 0) begin
        $error("unexpected word: visible %0b x %0d y %0d", out_visible, out_screen_x,
               out_screen_y);
        n_errors = n_errors + 1;
      end else begin
        e = expected_pixels.pop_front();
        if (out_visible) n_visible <= n_visible + 1;
        if (out_visible !== e.vis) begin
          $error("visible: expected %0b got %0b", e.vis, out_visible);
          n_errors = n_errors + 1;
        end
        if (out_screen_x !== e.sx) begin
          $error("screen_x: expected %0d got %0d", e.sx, out_screen_x);
          n_errors = n_errors + 1;
        end
        if (out_screen_y !== e.sy) begin
          $error("screen_y: expected %0d got %0d", e.sy, out_screen_y);
          n_errors = n_errors + 1;
        end
      end
    end
    stall_phase <= stall_phase + 1;
    if (long_stall > 0) begin
      long_stall <= long_stall - 1;
      out_ready <= 1'b0;
    end else if (stall_phase % 400 < 150) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < REG_WIDTH) view_mtx[idx] = val;
    else if (idx == REG_WIDTH) vp_w = val[SCR_W-1:0];
    else vp_h = val[SCR_W-1:0];
  endtask

  task automatic drain_all();
    while (pending_points.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] q16(int v);
    return v << FRAC_BITS;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 400 << FRAC_BITS)) - (200 << FRAC_BITS);
    endcase
  endfunction

  task automatic load_camera(bit wild);
    logic [31:0] c [12];
    for (int i = 0; i < 12; i++) begin
      if (wild) c[i] = $urandom();
      else c[i] = $signed($urandom_range(0, 4 << FRAC_BITS)) - (2 << FRAC_BITS);
    end
    if (!wild) c[11] = $urandom_range(0, 50 << FRAC_BITS);
    for (int r = 0; r < MTX_REGS; r++)
      write_reg(cfg_reg_t'(r), {c[2 * r + 1], c[2 * r]});
  endtask

  task automatic push_points(int n);
    point_t p;
    for (int i = 0; i < n; i++) begin
      p.px = rand_coord();
      p.py = rand_coord();
      p.pz = rand_coord();
      pending_points.push_back(p);
    end
  endtask

  initial begin
    point_t p;
    for (int i = 0; i < MTX_REGS; i++) view_mtx[i] = '0;
    vp_w = 1920;
    vp_h = 1080;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // reset matrix: w is zero, all invisible
    p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0};
    pending_points.push_back(p);
    drain_all();
    // identity-like camera with w from z
    write_reg(REG_ROW0_01, {32'h0, q16(1)});
    write_reg(REG_ROW0_23, {32'h0, 32'h0});
    write_reg(REG_ROW1_01, {q16(1), 32'h0});
    write_reg(REG_ROW1_23, {32'h0, 32'h0});
    write_reg(REG_ROW3_01, {32'h0, 32'h0});
    write_reg(REG_ROW3_23, {32'h0, q16(1)});
    begin
      int zs [6] = '{654, 655, 656, 1 << 16, -1, 32'h7FFF_FFFF};
      foreach (zs[i]) begin
        pending_points.push_back('{q16(3), -q16(2), zs[i]});
        pending_points.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, zs[i]});
        pending_points.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, zs[i]});
      end
    end
    drain_all();
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 16384);
    pending_points.push_back('{q16(1), q16(1), q16(1)});
    pending_points.push_back('{-q16(5), q16(7), 700});
    drain_all();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 32767);
    pending_points.push_back('{q16(1), -q16(1), 655});
    drain_all();
    for (int phase = 0; phase < 10; phase++) begin
      load_camera(phase % 4 == 3);
      case (phase % 3)
        0: begin write_reg(REG_WIDTH, 16384); write_reg(REG_HEIGHT, 1); end
        1: begin write_reg(REG_WIDTH, $urandom_range(1, 16384));
                 write_reg(REG_HEIGHT, $urandom_range(1, 16384)); end
        default: begin write_reg(REG_WIDTH, $urandom_range(0, 32767));
                       write_reg(REG_HEIGHT, $urandom_range(0, 32767)); end
      endcase
      if (phase == 2) begin
        @(posedge clk);
        long_stall <= 300;
      end
      push_points(120);
      if (phase == 5) begin
        while (pending_points.size() > 60) @(posedge clk);
        hold_off = 1'b1;
        while (expected_pixels.size() > 0 || in_valid) @(posedge clk);
        hold_off = 1'b0;
      end
      drain_all();
    end
    write_reg(cfg_reg_t'(REG_HEIGHT), 1080);
    $display("covered %0d points, %0d visible, ten camera settings plus edge viewports",
             n_pixels, n_visible);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
